// ----- rtl/paw_pkg.sv -----
// Package: shared constants and register codes of the PID controller.
`timescale 1ns / 1ps
package paw_pkg;

  // Default widths of the error sample and of the running integral
  localparam int ERR_WIDTH_DEF = 16;
  localparam int ACC_WIDTH_DEF = 32;

  // Fixed widths of gains, limits and drive output
  localparam int GAIN_WIDTH  = 16;
  localparam int DRIVE_WIDTH = 16;
  localparam int FRAC_BITS   = 8;

  // Configuration port
  localparam int APB_ADDR_WIDTH = 5;
  localparam int APB_DATA_WIDTH = 32;

  // Register indexes (byte address = 4 * index)
  typedef enum logic [2:0] {
    REG_GAIN_P    = 3'd0,
    REG_GAIN_I    = 3'd1,
    REG_GAIN_D    = 3'd2,
    REG_OUT_UPPER = 3'd3,
    REG_OUT_LOWER = 3'd4
  } reg_idx_t;

  // Register reset values
  localparam logic [GAIN_WIDTH-1:0]  GAIN_P_RST    = 16'd384;
  localparam logic [GAIN_WIDTH-1:0]  GAIN_I_RST    = 16'd26;
  localparam logic [GAIN_WIDTH-1:0]  GAIN_D_RST    = 16'd128;
  localparam logic [DRIVE_WIDTH-1:0] OUT_UPPER_RST = 16'h7FFF;
  localparam logic [DRIVE_WIDTH-1:0] OUT_LOWER_RST = 16'h8000;

endpackage

// ----- rtl/paw_if.sv -----
// Interfaces: error sample channel and drive result channel.
`timescale 1ns / 1ps
interface paw_err_if #(
  parameter int W = 16
) ();
  logic                valid;
  logic                ready;
  logic signed [W-1:0] err_sample;

  modport source (output valid, output err_sample, input ready);
  modport sink   (input valid, input err_sample, output ready);
endinterface

interface paw_drive_if ();
  logic               valid;
  logic               ready;
  logic signed [15:0] drive_value;
  logic               clamped;

  modport source (output valid, output drive_value, output clamped, input ready);
  modport sink   (input valid, input drive_value, input clamped, output ready);
endinterface

// ----- rtl/pid_with_anti_windup.sv -----
// Top level: PID controller with conditional-integration anti-windup.
// An accepted error item passes through the input register, then the result register,
//   to its drive item; the integral and prior error update with the result.
// Throughput: one item per cycle unless the drive channel stalls; the single-pass arithmetic
//   between the two registers (three multiplies, sum, clamp) closes the integral loop each cycle.
// Reset (rst, synchronous): clears both valid flags, integral and prior error,
//   and loads the gain and limit registers with their defaults.
`timescale 1ns / 1ps
module pid_with_anti_windup
  import paw_pkg::*;
#(
  parameter int ERR_WIDTH = ERR_WIDTH_DEF,
  parameter int ACC_WIDTH = ACC_WIDTH_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  // configuration port
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [APB_ADDR_WIDTH-1:0] paddr,
  input  logic [APB_DATA_WIDTH-1:0] pwdata,
  output logic [APB_DATA_WIDTH-1:0] prdata,
  output logic                      pready,
  // item channels
  paw_err_if.sink                   err,
  paw_drive_if.source               drive
);

  // Derived widths
  localparam int SAT_W  = ((ACC_WIDTH > ERR_WIDTH) ? ACC_WIDTH : ERR_WIDTH) + 1;
  localparam int DER_W  = ERR_WIDTH + 1;
  localparam int PP_W   = GAIN_WIDTH + ERR_WIDTH;
  localparam int PI_W   = GAIN_WIDTH + ACC_WIDTH;
  localparam int PD_W   = GAIN_WIDTH + DER_W;
  localparam int SUM_W  = ((PI_W > PD_W) ? PI_W : PD_W) + 2;
  localparam int Y_W    = SUM_W - FRAC_BITS;

  // Integral bounds at the saturation width
  localparam logic signed [SAT_W-1:0] ACC_MAX =
    {{(SAT_W - ACC_WIDTH + 1){1'b0}}, {(ACC_WIDTH - 1){1'b1}}};
  localparam logic signed [SAT_W-1:0] ACC_MIN = ~ACC_MAX;

  // Configuration registers
  logic signed [GAIN_WIDTH-1:0]  gain_p, gain_i, gain_d;
  logic signed [DRIVE_WIDTH-1:0] out_upper, out_lower;
  logic                          cfg_wr;
  logic [2:0]                    cfg_idx;

  assign pready  = 1'b1;
  assign cfg_idx = paddr[4:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      gain_p    <= GAIN_P_RST;
      gain_i    <= GAIN_I_RST;
      gain_d    <= GAIN_D_RST;
      out_upper <= OUT_UPPER_RST;
      out_lower <= OUT_LOWER_RST;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_GAIN_P:    gain_p    <= pwdata[GAIN_WIDTH-1:0];
        REG_GAIN_I:    gain_i    <= pwdata[GAIN_WIDTH-1:0];
        REG_GAIN_D:    gain_d    <= pwdata[GAIN_WIDTH-1:0];
        REG_OUT_UPPER: out_upper <= pwdata[DRIVE_WIDTH-1:0];
        REG_OUT_LOWER: out_lower <= pwdata[DRIVE_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  // Register read-back, sign extended to the bus
  always_comb begin
    case (cfg_idx)
      REG_GAIN_P:    prdata = APB_DATA_WIDTH'(gain_p);
      REG_GAIN_I:    prdata = APB_DATA_WIDTH'(gain_i);
      REG_GAIN_D:    prdata = APB_DATA_WIDTH'(gain_d);
      REG_OUT_UPPER: prdata = APB_DATA_WIDTH'(out_upper);
      REG_OUT_LOWER: prdata = APB_DATA_WIDTH'(out_lower);
      default:       prdata = '0;
    endcase
  end

  // Handshake: input register advances when it is empty or the result register is free or drains
  logic                        in_valid;
  logic signed [ERR_WIDTH-1:0] in_err;
  logic                        out_valid;
  logic                        advance;

  assign advance   = !out_valid || drive.ready;
  assign err.ready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (err.ready) begin
      in_valid <= err.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (err.valid && err.ready) begin
      in_err <= err.err_sample;
    end
  end

  // Loop state
  logic signed [ACC_WIDTH-1:0] integral_sum, integral_sum_next;
  logic signed [ERR_WIDTH-1:0] prior_error;

  // Saturating integral update
  logic signed [SAT_W-1:0] int_raw;
  logic signed [ACC_WIDTH-1:0] int_sat;

  always_comb begin
    int_raw = SAT_W'(integral_sum) + SAT_W'(in_err);
    if (int_raw > ACC_MAX) begin
      int_sat = ACC_MAX[ACC_WIDTH-1:0];
    end else if (int_raw < ACC_MIN) begin
      int_sat = ACC_MIN[ACC_WIDTH-1:0];
    end else begin
      int_sat = int_raw[ACC_WIDTH-1:0];
    end
  end

  // Three products and their sum
  logic signed [DER_W-1:0] deriv;
  logic signed [PP_W-1:0]  p_prop;
  logic signed [PI_W-1:0]  p_int;
  logic signed [PD_W-1:0]  p_der;
  logic signed [SUM_W-1:0] sum;
  logic signed [Y_W-1:0]   y;
  logic signed [Y_W-1:0]   hi_x, lo_x;

  assign deriv  = DER_W'(in_err) - DER_W'(prior_error);
  assign p_prop = PP_W'(gain_p) * PP_W'(in_err);
  assign p_int  = PI_W'(gain_i) * PI_W'(int_sat);
  assign p_der  = PD_W'(gain_d) * PD_W'(deriv);
  assign sum    = SUM_W'(p_prop) + SUM_W'(p_int) + SUM_W'(p_der);
  // arithmetic shift floors the sum of the Q8.8-gain products to an integer
  assign y      = Y_W'(sum >>> FRAC_BITS);
  assign hi_x   = Y_W'(out_upper);
  assign lo_x   = Y_W'(out_lower);

  // Clamp, upper test first
  logic signed [DRIVE_WIDTH-1:0] drive_next;
  logic                          clip;

  always_comb begin
    priority if (y > hi_x) begin
      drive_next = out_upper;
      clip       = 1'b1;
    end else if (y < lo_x) begin
      drive_next = out_lower;
      clip       = 1'b1;
    end else begin
      drive_next = y[DRIVE_WIDTH-1:0];
      clip       = 1'b0;
    end
  end

  // A clamped sample is not integrated
  assign integral_sum_next = clip ? integral_sum : int_sat;

  always_ff @(posedge clk) begin
    if (rst) begin
      integral_sum <= '0;
      prior_error  <= '0;
    end else if (in_valid && advance) begin
      integral_sum <= integral_sum_next;
      prior_error  <= in_err;
    end
  end

  // Result register
  logic signed [DRIVE_WIDTH-1:0] drive_r;
  logic                          clamped_r;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && advance) begin
      drive_r   <= drive_next;
      clamped_r <= clip;
    end
  end

  assign drive.valid       = out_valid;
  assign drive.drive_value = drive_r;
  assign drive.clamped     = clamped_r;

endmodule
